// ===== src/lst_pkg.sv =====
// lst_pkg: shared constants, types and functions of the lamp test sequencer
// no dependencies

package lst_pkg;

    localparam int NUM_LEDS = 11;
    localparam int EXT_W    = 16;
    localparam int IDX_W    = 4;
    localparam int STEP_W   = 4;
    localparam int TICK_W   = 8;
    localparam int EXP_W    = 8;
    localparam int GPIO_W   = NUM_LEDS - 4;

    localparam logic [TICK_W-1:0] LIT_TICKS_RESET = 8'd50;
    localparam logic [EXP_W-1:0]  EXPANDER_MASK   = 8'hF0;
    localparam logic [STEP_W-1:0] LAST_STEP       = STEP_W'(NUM_LEDS);

    typedef logic [NUM_LEDS-1:0] t_leds;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_SET  = 1'b1
    } t_func;

    // one-hot LED mask for a step of the fixed lamp order 0,1,2,4,3,8,7,6,5,9,10
    function automatic t_leds lamp_bit(input logic [STEP_W-1:0] step);
        t_leds m;
        m = '0;
        case (step)
            4'd0:    m[0]  = 1'b1;
            4'd1:    m[1]  = 1'b1;
            4'd2:    m[2]  = 1'b1;
            4'd3:    m[4]  = 1'b1;
            4'd4:    m[3]  = 1'b1;
            4'd5:    m[8]  = 1'b1;
            4'd6:    m[7]  = 1'b1;
            4'd7:    m[6]  = 1'b1;
            4'd8:    m[5]  = 1'b1;
            4'd9:    m[9]  = 1'b1;
            4'd10:   m[10] = 1'b1;
            default: m = '0;
        endcase
        return m;
    endfunction

    // LED0 at bit 7 down to LED3 at bit 4, low nibble zero
    function automatic logic [EXP_W-1:0] expander_map(input t_leds leds);
        logic [EXP_W-1:0] e;
        e = {leds[0], leds[1], leds[2], leds[3], 4'b0000};
        return e & EXPANDER_MASK;
    endfunction

endpackage

// ===== src/lst_in_if.sv =====
// lst_in_if: input item channel (tick or external bit write)
// depends on lst_pkg

interface lst_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [lst_pkg::IDX_W-1:0]  led_index;
    logic                       led_on;

    modport source (output valid, output func, output led_index, output led_on, input ready);
    modport sink   (input valid, input func, input led_index, input led_on, output ready);
endinterface

// ===== src/lst_out_if.sv =====
// lst_out_if: result channel with display word and split LED drive bits
// depends on lst_pkg

interface lst_out_if;
    logic                        valid;
    logic                        ready;
    logic [lst_pkg::NUM_LEDS-1:0] display_word;
    logic [lst_pkg::EXP_W-1:0]   expander_bits;
    logic [lst_pkg::GPIO_W-1:0]  gpio_bits;
    logic                        test_done;

    modport source (output valid, output display_word, output expander_bits,
                    output gpio_bits, output test_done, input ready);
    modport sink   (input valid, input display_word, input expander_bits,
                    input gpio_bits, input test_done, output ready);
endinterface

// ===== src/lst_cfg_if.sv =====
// lst_cfg_if: configuration write channel for lit_ticks
// depends on lst_pkg

interface lst_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lst_pkg::TICK_W-1:0]  lit_ticks;

    modport source (output valid, output lit_ticks, input ready);
    modport sink   (input valid, input lit_ticks, output ready);
endinterface

// ===== src/lst_core.sv =====
// lst_core: lamp test state, external word and next shown pattern
// depends on lst_pkg

module lst_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lst_pkg::TICK_W-1:0]   i_cfg_lit_ticks,
    input  logic                         i_accept,
    input  logic                         i_func,
    input  logic [lst_pkg::IDX_W-1:0]    i_led_index,
    input  logic                         i_led_on,
    output logic [lst_pkg::NUM_LEDS-1:0] o_shown,
    output logic                         o_done
);

    logic [lst_pkg::TICK_W-1:0]   r_lit_ticks;
    logic [lst_pkg::TICK_W-1:0]   r_hold, n_hold;
    logic [lst_pkg::STEP_W-1:0]   r_step, n_step;
    logic                         r_dark, n_dark;
    logic                         r_done, n_done;
    logic [lst_pkg::NUM_LEDS-1:0] r_test, n_test;
    logic [lst_pkg::EXT_W-1:0]    r_ext, n_ext;
    logic [lst_pkg::NUM_LEDS-1:0] r_shown, n_shown;

    logic [lst_pkg::STEP_W-1:0]   eff_step;
    logic                         eff_dark;
    logic                         is_tick;
    logic [lst_pkg::EXT_W-1:0]    ext_bit;

    always_comb begin
        is_tick  = i_accept && (lst_pkg::t_func'(i_func) == lst_pkg::FUNC_TICK);
        // end of light phase rolls straight into dark phase step 0
        eff_dark = r_dark || (r_step == lst_pkg::LAST_STEP);
        eff_step = (r_step == lst_pkg::LAST_STEP && !r_dark) ? '0 : r_step;
        ext_bit  = lst_pkg::EXT_W'(1) << i_led_index;

        n_hold  = r_hold;
        n_step  = r_step;
        n_dark  = r_dark;
        n_done  = r_done;
        n_test  = r_test;
        n_ext   = r_ext;
        n_shown = r_shown;

        if (i_accept && lst_pkg::t_func'(i_func) == lst_pkg::FUNC_SET) begin
            n_ext = i_led_on ? (r_ext | ext_bit) : (r_ext & ~ext_bit);
        end

        if (is_tick) begin
            if (!r_done) begin
                if (r_hold != '0) begin
                    n_hold = r_hold - 1'b1;
                end else if (eff_step == lst_pkg::LAST_STEP && eff_dark) begin
                    n_done = 1'b1;
                end else begin
                    n_hold = r_lit_ticks;
                    n_dark = eff_dark;
                    n_step = eff_step + 1'b1;
                    if (eff_dark) begin
                        n_test = r_test & ~lst_pkg::lamp_bit(eff_step);
                    end else begin
                        n_test = r_test | lst_pkg::lamp_bit(eff_step);
                    end
                end
            end
            n_shown = n_done ? r_ext[lst_pkg::NUM_LEDS-1:0] : n_test;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit_ticks <= lst_pkg::LIT_TICKS_RESET;
            r_hold      <= '0;
            r_step      <= '0;
            r_dark      <= 1'b0;
            r_done      <= 1'b0;
            r_test      <= '0;
            r_ext       <= '0;
            r_shown     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_lit_ticks <= i_cfg_lit_ticks;
            end
            r_hold  <= n_hold;
            r_step  <= n_step;
            r_dark  <= n_dark;
            r_done  <= n_done;
            r_test  <= n_test;
            r_ext   <= n_ext;
            r_shown <= n_shown;
        end
    end

    assign o_shown = n_shown;
    assign o_done  = n_done;

endmodule

// ===== src/led_lamp_test_sequencer_unit.sv =====
// led_lamp_test_sequencer_unit: top level, item handshake and result register
// depends on lst_pkg, lst_in_if, lst_out_if, lst_cfg_if, lst_core
//
//  channel   dir  payload                                            handshake
//  i_item    in   func, led_index, led_on                            valid/ready
//  o_result  out  display_word, expander_bits, gpio_bits, test_done  valid/ready
//  i_cfg     in   lit_ticks                                          valid/ready
//
// one item per cycle unless stalled; each result appears in the cycle after its transaction
// i_item.ready is high while the result register is empty or being taken
// i_cfg.ready is always high; writes take effect on the next item
// synchronous active-low reset: lamp test restarts, lit_ticks returns to 50

module led_lamp_test_sequencer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lst_in_if.sink     i_item,
    lst_out_if.source  o_result,
    lst_cfg_if.sink    i_cfg
);

    logic                         accept;
    logic                         cfg_we;
    logic [lst_pkg::NUM_LEDS-1:0] n_shown;
    logic                         n_done;
    logic                         r_valid;
    logic [lst_pkg::NUM_LEDS-1:0] r_shown;
    logic                         r_done;

    assign i_item.ready = !r_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;
    assign cfg_we       = i_cfg.valid;

    lst_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_lit_ticks (i_cfg.lit_ticks),
        .i_accept        (accept),
        .i_func          (i_item.func),
        .i_led_index     (i_item.led_index),
        .i_led_on        (i_item.led_on),
        .o_shown         (n_shown),
        .o_done          (n_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_shown <= n_shown;
            r_done  <= n_done;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.display_word  = r_shown;
    assign o_result.expander_bits = lst_pkg::expander_map(r_shown);
    assign o_result.gpio_bits     = r_shown[lst_pkg::NUM_LEDS-1:4];
    assign o_result.test_done     = r_done;

endmodule

// ===== src/lst_checker.sv =====
// lst_checker: port-level assertions for the lamp test sequencer
// depends on lst_pkg; bound to led_lamp_test_sequencer_unit

module lst_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [lst_pkg::NUM_LEDS-1:0] i_display_word,
    input logic [lst_pkg::EXP_W-1:0]    i_expander_bits,
    input logic [lst_pkg::GPIO_W-1:0]   i_gpio_bits,
    input logic                         i_test_done
);

    logic r_seen_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_done <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_test_done) begin
            r_seen_done <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_display_word))
        else $error("result changed while stalled");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_valid && i_in_ready && i_out_valid && !i_out_ready))
        else $error("transaction accepted over a pending result");

    a_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_gpio_bits == i_display_word[lst_pkg::NUM_LEDS-1:4]
            && i_expander_bits == {i_display_word[0], i_display_word[1],
                                   i_display_word[2], i_display_word[3], 4'b0000})
        else $error("expander or gpio bits disagree with display word");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_done |-> i_test_done)
        else $error("test done dropped");

endmodule

bind led_lamp_test_sequencer_unit lst_checker u_lst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_display_word  (o_result.display_word),
    .i_expander_bits (o_result.expander_bits),
    .i_gpio_bits     (o_result.gpio_bits),
    .i_test_done     (o_result.test_done)
);
